### hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Field widths
  localparam int unsigned RAW_T_W  = 16;
  localparam int unsigned RAW_P_W  = 19;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned PRES_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Divider shapes: temperature |mc*2048| / |x1+md|, pressure b7 / b4
  localparam int unsigned TDIV_NW = 27;
  localparam int unsigned TDIV_DW = 20;
  localparam int unsigned PDIV_NW = 32;
  localparam int unsigned PDIV_DW = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

  // Compensation constants
  localparam logic signed [27:0] B6_OFFSET = 28'sd4000;
  localparam logic signed [27:0] T_ROUND   = 28'sd8;
  localparam logic [31:0]        B4_BIAS   = 32'd32768;
  localparam logic [15:0]        B7_SCALE  = 16'd50000;
  localparam logic [11:0]        P_C1      = 12'd3038;
  localparam logic [12:0]        P_C2      = 13'd7357;
  localparam logic signed [47:0] P_C3      = 48'sd3791;
  localparam logic signed [15:0] TEMP_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN  = -16'sh8000;
  localparam logic [PRES_W-1:0]  PRES_MAX  = 18'h3FFFF;

  // Calibration set as decoded from the packed registers
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic        [1:0]  oss;
  } cal_t;

  // Sideband carried through the pressure divider
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     err;
    logic                     big;
  } pside_t;

endpackage

### hdl/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels: raw sample input, compensated result, register write.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  import bpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAW_T_W-1:0] raw_temperature;
  logic [RAW_P_W-1:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_decidegrees;
  logic        [PRES_W-1:0] pressure_pascal;
  logic                     status;

  modport source (output valid, temperature_decidegrees, pressure_pascal, status,
                  input ready);
  modport sink   (input valid, temperature_decidegrees, pressure_pascal, status,
                  output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bpc_regs.sv
// ----------------------------------------------------------------------------
// bpc_regs
// Calibration and oversampling registers, decoded into the calibration set.
// ----------------------------------------------------------------------------
module bpc_regs
  import bpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_cfg_if.sink   cfg_i,
  output cal_t      cal_o
);

  logic [CFG_DAT_W-1:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]           oss_q;

  assign cfg_i.ready = 1'b1;

  // Register write; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0;
      ac34_q <= '0;
      ac56_q <= '0;
      b12_q  <= '0;
      mcmd_q <= '0;
      oss_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_AC1_AC2: ac12_q <= cfg_i.data;
        REG_AC3_AC4: ac34_q <= cfg_i.data;
        REG_AC5_AC6: ac56_q <= cfg_i.data;
        REG_B1_B2:   b12_q  <= cfg_i.data;
        REG_MC_MD:   mcmd_q <= cfg_i.data;
        REG_OSS:     oss_q  <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // Field decode
  always_comb begin
    cal_o.ac1 = $signed(ac12_q[31:16]);
    cal_o.ac2 = $signed(ac12_q[15:0]);
    cal_o.ac3 = $signed(ac34_q[31:16]);
    cal_o.ac4 = ac34_q[15:0];
    cal_o.ac5 = ac56_q[31:16];
    cal_o.ac6 = ac56_q[15:0];
    cal_o.b1  = $signed(b12_q[31:16]);
    cal_o.b2  = $signed(b12_q[15:0]);
    cal_o.mc  = $signed(mcmd_q[31:16]);
    cal_o.md  = $signed(mcmd_q[15:0]);
    cal_o.oss = oss_q;
  end

endmodule

### hdl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
#(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 17,
  parameter int unsigned SW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // word holds the unconsumed dividend bits on top, quotient bits below
  logic [NW-1:0] word_q [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] vld_q;

  logic [NW-1:0] word_in [NW];
  logic [DW-1:0] rem_in  [NW];
  logic [DW-1:0] den_in  [NW];
  logic [SW-1:0] side_in [NW];
  logic [NW-1:0] vld_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [NW-1:0] word_d;

    if (i == 0) begin : g_head
      assign word_in[i] = num_i;
      assign rem_in[i]  = '0;
      assign den_in[i]  = den_i;
      assign side_in[i] = side_i;
      assign vld_in[i]  = valid_i;
    end else begin : g_body
      assign word_in[i] = word_q[i-1];
      assign rem_in[i]  = rem_q[i-1];
      assign den_in[i]  = den_q[i-1];
      assign side_in[i] = side_q[i-1];
      assign vld_in[i]  = vld_q[i-1];
    end

    // Shift in one dividend bit, trial subtract
    always_comb begin
      trial  = {rem_in[i], word_in[i][NW-1]};
      diff   = trial - {1'b0, den_in[i]};
      ge     = (trial >= {1'b0, den_in[i]});
      rem_d  = ge ? diff[DW-1:0] : trial[DW-1:0];
      word_d = {word_in[i][NW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        word_q[i] <= word_d;
        rem_q[i]  <= rem_d;
        den_q[i]  <= den_in[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = word_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

### hdl/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Temperature compensation through b5, then b3, b4 and b7 for the pressure.
// ----------------------------------------------------------------------------
module bpc_front
  import bpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cal_t                 cal_i,
  input  logic                 valid_i,
  input  logic [RAW_T_W-1:0]   raw_temperature_i,
  input  logic [RAW_P_W-1:0]   raw_pressure_i,
  output logic                 valid_o,
  output logic [PDIV_NW-1:0]   num_o,
  output logic [PDIV_DW-1:0]   den_o,
  output pside_t               side_o
);

  typedef struct packed {
    logic signed [18:0] x1;
    logic [RAW_P_W-1:0] up;
    logic               neg;
    logic               zt;
  } tside_t;

  // Stage A: ut - ac6
  logic               va_q;
  logic signed [16:0] d_q;
  logic [RAW_P_W-1:0] upa_q;
  // Stage B: x ac5
  logic               vb_q;
  logic signed [33:0] m_q;
  logic [RAW_P_W-1:0] upb_q;
  // Stage C: x1 and divisor
  logic               vc_q;
  logic signed [18:0] x1_q;
  logic signed [19:0] den_q;
  logic [RAW_P_W-1:0] upc_q;

  logic signed [33:0] m_d;
  logic signed [19:0] den_d;
  logic [15:0]        mc_abs;
  logic [TDIV_DW-1:0] den_abs;
  tside_t             tside_in, tside_out;
  logic               vdiv;
  logic [TDIV_NW-1:0] tquo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign m_d   = d_q * $signed({1'b0, cal_i.ac5});
  assign den_d = $signed(m_q[33:15]) + cal_i.md;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.ac6});
      upa_q <= raw_pressure_i;
      m_q   <= m_d;
      upb_q <= upa_q;
      x1_q  <= $signed(m_q[33:15]);
      den_q <= den_d;
      upc_q <= upb_q;
    end
  end

  // Magnitude division, sign restored afterwards (truncation toward zero)
  always_comb begin
    mc_abs       = cal_i.mc[15] ? 16'(-cal_i.mc) : cal_i.mc;
    den_abs      = den_q[19] ? 20'(-den_q) : den_q;
    tside_in.x1  = x1_q;
    tside_in.up  = upc_q;
    tside_in.neg = cal_i.mc[15] ^ den_q[19];
    tside_in.zt  = (den_q == '0);
  end

  bpc_div #(
    .NW (TDIV_NW),
    .DW (TDIV_DW),
    .SW ($bits(tside_t))
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vc_q),
    .num_i   ({mc_abs, 11'd0}),
    .den_i   (den_abs),
    .side_i  (tside_in),
    .valid_o (vdiv),
    .quo_o   (tquo),
    .side_o  (tside_out)
  );

  // Stage D: b5
  logic               vd_q, ve_q, vf_q, vg_q, vh_q, vi_q;
  logic signed [27:0] b5_q;
  logic signed [27:0] x2_t;
  logic [RAW_P_W-1:0] upd_q, upe_q, upf_q, upg_q, uph_q;
  logic               ztd_q, zte_q, ztf_q, ztg_q, zth_q, zti_q;
  // Stage E: temperature and b6
  logic signed [27:0] tw;
  logic signed [23:0] t24;
  logic signed [TEMP_W-1:0] t_sat;
  logic signed [TEMP_W-1:0] te_q, tf_q, tg_q, th_q, ti_q;
  logic signed [27:0] b6_q;
  // Stage F: products of b6
  logic signed [55:0] sqf_q;
  logic signed [43:0] pa2_q, pa3_q;
  // Stage G: products of the square
  logic signed [59:0] pb2_q, pb1_q;
  logic signed [32:0] x2a_q;
  logic signed [30:0] x1b_q;
  // Stage H: b3 and x3 (low bits)
  logic signed [48:0] x1a;
  logic signed [49:0] x3a;
  logic signed [50:0] vsum;
  logic signed [54:0] vext, vsh;
  logic signed [44:0] x3bs;
  logic [31:0]        b3l_q, x3bl_q;
  // Stage I: b4 and b7
  logic [31:0]        b4f_q, b7_q;
  logic [15:0]        scale;
  logic [PDIV_DW-1:0] b4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vdiv;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
    end
  end

  always_comb begin
    x2_t = tside_out.neg ? -$signed({1'b0, tquo}) : $signed({1'b0, tquo});
    tw   = b5_q + T_ROUND;
    t24  = tw[27:4];
    if (t24 > 24'sd32767) begin
      t_sat = TEMP_MAX;
    end else if (t24 < -24'sd32768) begin
      t_sat = TEMP_MIN;
    end else begin
      t_sat = t24[15:0];
    end
    // b3 = ((4*ac1 + x3) << oss + 2) >> 2, only its low word is used
    x1a   = $signed(pb2_q[59:11]);
    x3a   = x1a + x2a_q;
    vsum  = $signed({cal_i.ac1, 2'b00}) + x3a;
    vext  = vsum;
    vsh   = vext <<< cal_i.oss;
    vsh   = vsh + 55'sd2;
    x3bs  = x1b_q + $signed(pb1_q[59:16]) + 45'sd2;
    scale = B7_SCALE >> cal_i.oss;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b5_q   <= tside_out.x1 + x2_t;
      upd_q  <= tside_out.up;
      ztd_q  <= tside_out.zt;

      te_q   <= t_sat;
      b6_q   <= b5_q - B6_OFFSET;
      upe_q  <= upd_q;
      zte_q  <= ztd_q;

      sqf_q  <= b6_q * b6_q;
      pa2_q  <= cal_i.ac2 * b6_q;
      pa3_q  <= cal_i.ac3 * b6_q;
      tf_q   <= te_q;
      upf_q  <= upe_q;
      ztf_q  <= zte_q;

      pb2_q  <= cal_i.b2 * $signed(sqf_q[55:12]);
      pb1_q  <= cal_i.b1 * $signed(sqf_q[55:12]);
      x2a_q  <= $signed(pa2_q[43:11]);
      x1b_q  <= $signed(pa3_q[43:13]);
      tg_q   <= tf_q;
      upg_q  <= upf_q;
      ztg_q  <= ztf_q;

      b3l_q  <= vsh[33:2];
      x3bl_q <= x3bs[33:2];
      th_q   <= tg_q;
      uph_q  <= upg_q;
      zth_q  <= ztg_q;

      b4f_q  <= {16'd0, cal_i.ac4} * (x3bl_q + B4_BIAS);
      b7_q   <= ({13'd0, uph_q} - b3l_q) * {16'd0, scale};
      ti_q   <= th_q;
      zti_q  <= zth_q;
    end
  end

  // Divider hand-off; a large b7 is divided as is and the quotient doubled
  assign b4          = b4f_q[31:15];
  assign valid_o     = vi_q;
  assign num_o       = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
  assign den_o       = b4;
  assign side_o.temp = ti_q;
  assign side_o.err  = zti_q | (b4 == '0);
  assign side_o.big  = b7_q[31];

endmodule

### hdl/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back
// Pressure polynomial correction, saturation and the result register.
// ----------------------------------------------------------------------------
module bpc_back
  import bpc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [PDIV_NW-1:0]       quo_i,
  input  pside_t                   side_i,
  output logic                     valid_o,
  output logic signed [TEMP_W-1:0] temp_o,
  output logic [PRES_W-1:0]        pres_o,
  output logic                     status_o
);

  logic               vj_q, vk_q, vl_q, vm_q;
  logic [32:0]        pj_q, pk_q, pl_q;
  logic signed [TEMP_W-1:0] tj_q, tk_q, tl_q;
  logic               ej_q, ek_q, el_q;
  logic [49:0]        sq2_q;
  logic [45:0]        m7_q;
  logic [45:0]        x1c_q;
  logic signed [30:0] x2c_q;
  logic [61:0]        prod;
  logic signed [46:0] nm;
  logic signed [47:0] csum, pf;
  logic signed [43:0] corr;
  logic [PRES_W-1:0]  p_sat;
  logic signed [TEMP_W-1:0] to_q;
  logic [PRES_W-1:0]  po_q;
  logic               so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vj_q <= 1'b0;
      vk_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en_i) begin
      vj_q <= valid_i;
      vk_q <= vj_q;
      vl_q <= vk_q;
      vm_q <= vl_q;
    end
  end

  // Correction terms and saturation
  always_comb begin
    prod = sq2_q * P_C1;
    nm   = -$signed({1'b0, m7_q});
    csum = $signed({2'b00, x1c_q}) + x2c_q + P_C3;
    corr = csum[47:4];
    pf   = $signed({15'd0, pl_q}) + corr;
    if (pf < 48'sd0) begin
      p_sat = '0;
    end else if (pf > $signed({30'd0, PRES_MAX})) begin
      p_sat = PRES_MAX;
    end else begin
      p_sat = pf[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pj_q  <= side_i.big ? {quo_i, 1'b0} : {1'b0, quo_i};
      tj_q  <= side_i.temp;
      ej_q  <= side_i.err;

      sq2_q <= pj_q[32:8] * pj_q[32:8];
      m7_q  <= pj_q * P_C2;
      pk_q  <= pj_q;
      tk_q  <= tj_q;
      ek_q  <= ej_q;

      x1c_q <= prod[61:16];
      x2c_q <= nm[46:16];
      pl_q  <= pk_q;
      tl_q  <= tk_q;
      el_q  <= ek_q;

      to_q  <= el_q ? '0 : tl_q;
      po_q  <= el_q ? '0 : p_sat;
      so_q  <= el_q;
    end
  end

  assign valid_o  = vm_q;
  assign temp_o   = to_q;
  assign pres_o   = po_q;
  assign status_o = so_q;

endmodule

### hdl/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer temperature and pressure compensation with calibration registers.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                        | accept
//  item_i    | in  | raw_temperature[15:0], raw_pressure[18:0]      | valid & ready
//  result_o  | out | temperature_decidegrees[15:0] s, pressure_pascal | valid & ready
//            |     | [17:0], status                                 |
//  cfg_i     | in  | index[2:0], data[31:0]                         | valid & ready
//
// One beat per clock while no result is stalled; the pipeline is the two
// bit-per-stage dividers (27 and 32 stages) plus 13 arithmetic stages.
// Reset clears all valid bits and the calibration registers; no clear pass.
// The whole pipeline holds while a result waits; item_i.ready is low then.
// cfg_i is always ready.
module barometric_pressure_compensation_top
  import bpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bpc_in_if.sink     item_i,
  bpc_out_if.source  result_o,
  bpc_cfg_if.sink    cfg_i
);

  cal_t               cal;
  logic               en;
  logic               fv;
  logic [PDIV_NW-1:0] fnum;
  logic [PDIV_DW-1:0] fden;
  pside_t             fside, pside;
  logic               pv;
  logic [PDIV_NW-1:0] pquo;

  // Global advance: move when the result register is free or being taken
  assign en           = !result_o.valid || result_o.ready;
  assign item_i.ready = en;

  bpc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cal_o  (cal)
  );

  bpc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .cal_i             (cal),
    .valid_i           (item_i.valid),
    .raw_temperature_i (item_i.raw_temperature),
    .raw_pressure_i    (item_i.raw_pressure),
    .valid_o           (fv),
    .num_o             (fnum),
    .den_o             (fden),
    .side_o            (fside)
  );

  bpc_div #(
    .NW (PDIV_NW),
    .DW (PDIV_DW),
    .SW ($bits(pside_t))
  ) u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_i   (fnum),
    .den_i   (fden),
    .side_i  (fside),
    .valid_o (pv),
    .quo_o   (pquo),
    .side_o  (pside)
  );

  bpc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pv),
    .quo_i    (pquo),
    .side_i   (pside),
    .valid_o  (result_o.valid),
    .temp_o   (result_o.temperature_decidegrees),
    .pres_o   (result_o.pressure_pascal),
    .status_o (result_o.status)
  );

`ifndef SYNTH
  // An error result carries zero readings
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.status |->
      result_o.temperature_decidegrees == '0 && result_o.pressure_pascal == '0)
    else $error("error result with nonzero readings");

  // A waiting result freezes the input side
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !item_i.ready)
    else $error("input accepted while result stalled");

  // A new result only appears after the pipeline advanced
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(item_i.ready))
    else $error("result appeared without pipeline advance");
`endif

endmodule

### bench/tb_barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation_top
// Self-checking bench for the barometric compensation block. A directed table
// covers reset calibration, a known datasheet-style sample, both zero divisor
// errors, all oversampling settings and extreme calibration words. Random
// phases follow, each with fresh calibration. Every result beat is checked
// against the typed reading of its row or an in-bench integer compensation
// model, with random gaps on both the sample and the result channel.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation_top
  import bpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 90;
  localparam int N_PHASES   = 6;
  localparam int PHASE_LEN  = 150;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic        [PRES_W-1:0] pres;
    logic                     status;
  } reading_t;

  // one directed row: a register write or a sample beat
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    logic [RAW_T_W-1:0]   ut;
    logic [RAW_P_W-1:0]   up;
    bit                   typed;
    reading_t             want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bpc_in_if  item_if();
  bpc_out_if res_if();
  bpc_cfg_if cfg_if();

  barometric_pressure_compensation_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (res_if.source),
    .cfg_i    (cfg_if.sink)
  );

  always #4 clk_i = ~clk_i;

  logic [31:0] cal_shadow [0:5];
  reading_t    pending_readings [$];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          sink_stall = 0;
  bit          sink_quiet = 1'b0;
  bit          src_quiet = 1'b0;

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  // integer compensation of one sample under the shadow calibration
  function automatic reading_t compensate(logic [15:0] ut, logic [18:0] up);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint x1, x2, x3, den, b5, b6, b3, t, p, sq;
    logic [31:0] b4, b7, q, x3w, diff;
    logic [63:0] prod;
    int oss;
    reading_t r;
    ac1 = $signed(cal_shadow[REG_AC1_AC2][31:16]);
    ac2 = $signed(cal_shadow[REG_AC1_AC2][15:0]);
    ac3 = $signed(cal_shadow[REG_AC3_AC4][31:16]);
    ac4 = longint'(cal_shadow[REG_AC3_AC4][15:0]);
    ac5 = longint'(cal_shadow[REG_AC5_AC6][31:16]);
    ac6 = longint'(cal_shadow[REG_AC5_AC6][15:0]);
    b1  = $signed(cal_shadow[REG_B1_B2][31:16]);
    b2  = $signed(cal_shadow[REG_B1_B2][15:0]);
    mc  = $signed(cal_shadow[REG_MC_MD][31:16]);
    md  = $signed(cal_shadow[REG_MC_MD][15:0]);
    oss = int'(cal_shadow[REG_OSS][1:0]);
    r = '{temp: '0, pres: '0, status: 1'b1};
    // temperature
    x1 = ((longint'(ut) - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;
    // pressure
    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    x3w = x3[31:0] + 32'd32768;
    prod = {48'd0, cal_shadow[REG_AC3_AC4][15:0]} * {32'd0, x3w};
    b4 = prod[31:0] >> 15;
    if (b4 == 0) return r;
    diff = {13'd0, up} - b3[31:0];
    prod = {32'd0, diff} * {32'd0, (32'd50000 >> oss)};
    b7 = prod[31:0];
    if (b7 < 32'h8000_0000) begin
      q = (b7 << 1) / b4;
      p = longint'({32'd0, q});
    end else begin
      q = b7 / b4;
      p = longint'({32'd0, q}) * 2;
    end
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;
    r.temp = t[15:0];
    r.pres = p[17:0];
    r.status = 1'b0;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // wait until every expected result has come, then let the pipe settle
  task automatic drain();
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write beat; entered and left at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx <= REG_OSS) cal_shadow[idx] = (idx == REG_OSS) ? {30'd0, data[1:0]} : data;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // sample beat; valid stays high into the next call when there is no gap
  task automatic send_sample(logic [15:0] ut, logic [18:0] up, bit typed, reading_t want);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid = 1'b1;
    item_if.raw_temperature = ut;
    item_if.raw_pressure = up;
    do @(posedge clk_i); while (!item_if.ready);
    pending_readings.push_back(typed ? want : compensate(ut, up));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base, int span);
    return base + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  // calibration for one random phase: mostly near a real part, some wild
  task automatic load_random_cal(int phase);
    logic [31:0] w [0:5];
    int mode;
    mode = (phase == 0) ? 1 : $urandom_range(0, 9);
    if (mode < 7) begin
      w[0] = {jitter(16'd408, 300), jitter(-16'sd72, 300)};
      w[1] = {jitter(-16'sd14383, 2000), jitter(16'd32741, 4000)};
      w[2] = {jitter(16'd32757, 4000), jitter(16'd23153, 4000)};
      w[3] = {jitter(16'd6190, 1000), jitter(16'd4, 40)};
      w[4] = {jitter(-16'sd8711, 2000), jitter(16'd2868, 800)};
    end else begin
      for (int i = 0; i < 5; i++) w[i] = $urandom();
    end
    w[5] = $urandom();
    for (int i = 0; i <= 5; i++) write_reg(CFG_IDX_W'(i), w[i]);
  endtask

  // result channel: random stalls, checked at the rising edge
  always @(negedge clk_i) begin
    if (sink_stall > 0) begin
      res_if.ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (!sink_quiet && $urandom_range(0, 99) < 20) sink_stall <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.temperature_decidegrees, res_if.pressure_pascal, res_if.status};
      if (pending_readings.size() == 0) begin
        report($sformatf("unexpected result t=%0d p=%0d st=%0d",
                         got.temp, got.pres, got.status));
      end else begin
        want = pending_readings.pop_front();
        if (got.temp !== want.temp)
          report($sformatf("temperature %0d, want %0d", got.temp, want.temp));
        if (got.pres !== want.pres)
          report($sformatf("pressure %0d, want %0d", got.pres, want.pres));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t plan [$];
    reading_t fault;
    fault = '{temp: '0, pres: '0, status: 1'b1};
    item_if.valid = 1'b0;
    item_if.raw_temperature = '0;
    item_if.raw_pressure = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i <= 5; i++) cal_shadow[i] = '0;

    // reset calibration: both divisors zero
    plan.push_back('{0, 0, 0, 16'h0000, 19'h00000, 1, fault});
    plan.push_back('{0, 0, 0, 16'hFFFF, 19'h7FFFF, 1, fault});
    // typical calibration and the classic sample
    plan.push_back('{1, REG_AC1_AC2, {16'd408, -16'sd72}, 0, 0, 0, fault});
    plan.push_back('{1, REG_AC3_AC4, {-16'sd14383, 16'd32741}, 0, 0, 0, fault});
    plan.push_back('{1, REG_AC5_AC6, {16'd32757, 16'd23153}, 0, 0, 0, fault});
    plan.push_back('{1, REG_B1_B2, {16'd6190, 16'd4}, 0, 0, 0, fault});
    plan.push_back('{1, REG_MC_MD, {-16'sd8711, 16'd2868}, 0, 0, 0, fault});
    plan.push_back('{1, REG_OSS, 32'd0, 0, 0, 0, fault});
    plan.push_back('{0, 0, 0, 16'd27898, 19'd23843, 1, '{16'sd150, 18'd69964, 1'b0}});
    plan.push_back('{0, 0, 0, 16'h0000, 19'h00000, 0, fault});
    plan.push_back('{0, 0, 0, 16'hFFFF, 19'h7FFFF, 0, fault});
    plan.push_back('{0, 0, 0, 16'h0000, 19'h7FFFF, 0, fault});
    plan.push_back('{0, 0, 0, 16'hFFFF, 19'h00000, 0, fault});
    // each oversampling setting; indexes past the list are ignored
    for (int o = 3; o >= 1; o--) begin
      plan.push_back('{1, REG_OSS, 32'hFFFF_FFFC | o, 0, 0, 0, fault});
      plan.push_back('{0, 0, 0, 16'd27898, 19'd23843 << o, 0, fault});
      plan.push_back('{0, 0, 0, 16'd30000, 19'h7FFFF, 0, fault});
    end
    plan.push_back('{1, 3'd6, 32'hFFFF_FFFF, 0, 0, 0, fault});
    plan.push_back('{1, 3'd7, 32'h0000_0000, 0, 0, 0, fault});
    plan.push_back('{0, 0, 0, 16'd27898, 19'd1, 0, fault});
    // pressure divisor zero: ac4 cleared
    plan.push_back('{1, REG_AC3_AC4, {-16'sd14383, 16'd0}, 0, 0, 0, fault});
    plan.push_back('{0, 0, 0, 16'd27898, 19'd23843, 1, fault});
    // temperature divisor zero: ac5 and md cleared
    plan.push_back('{1, REG_AC3_AC4, {-16'sd14383, 16'd32741}, 0, 0, 0, fault});
    plan.push_back('{1, REG_AC5_AC6, 32'd0, 0, 0, 0, fault});
    plan.push_back('{1, REG_MC_MD, {-16'sd8711, 16'd0}, 0, 0, 0, fault});
    plan.push_back('{0, 0, 0, 16'd27898, 19'd23843, 1, fault});
    // extreme calibration words
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i <= 5; i++)
        plan.push_back('{1, CFG_IDX_W'(i), k ? 32'h8000_8000 : 32'hFFFF_FFFF, 0, 0, 0, fault});
      plan.push_back('{0, 0, 0, 16'h0000, 19'h00000, 0, fault});
      plan.push_back('{0, 0, 0, 16'hFFFF, 19'h7FFFF, 0, fault});
      plan.push_back('{0, 0, 0, 16'h8000, 19'h40000, 0, fault});
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (i == 0 || !plan[i - 1].is_write) begin
          item_if.valid = 1'b0;
          drain();
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].ut, plan[i].up, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each with its own calibration
    for (int ph = 0; ph < N_PHASES; ph++) begin
      item_if.valid = 1'b0;
      drain();
      load_random_cal(ph);
      src_quiet = (ph == 2);
      sink_quiet = (ph == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 1 && n == PHASE_LEN / 2) begin
          // hold the sender until the pipe has emptied
          item_if.valid = 1'b0;
          while (pending_readings.size() != 0) @(negedge clk_i);
        end
        send_sample($urandom_range(0, 99) < 70 ? 16'($urandom_range(20000, 40000))
                                               : 16'($urandom()),
                    19'($urandom()), 0, fault);
      end
    end
    item_if.valid = 1'b0;
    src_quiet = 1'b0;
    sink_quiet = 1'b0;

    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
